FILE: hw/rtl/hcp_pkg.sv
package hcp_pkg;

  // field widths of the item ports
  localparam int KIND_W       = 2;
  localparam int SYMBOL_W     = 8;
  localparam int CODE_FIELD_W = 16;
  localparam int CODE_LEN_W   = 5;
  localparam int BYTE_W       = 8;

  // bit accumulator: 7 pending bits plus the longest code fit in three bytes
  localparam int PEND_W = 7;
  localparam int PCNT_W = 3;
  localparam int ACC_W  = 24;
  localparam int SUM_W  = 5;
  localparam int NB_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

endpackage

FILE: hw/rtl/huffman_code_table_bit_packer.sv
// Huffman code-table bit packer. Load transactions write a code and its length into a
// table of SYMBOL_COUNT entries held in one synchronous RAM with a per-entry valid bit,
// so the table reads as all zero length right after reset with no clearing pass. Encode
// transactions look the symbol up and append its code to a 7-bit pending accumulator,
// emitting each completed byte with the earliest stream bit at bit 0; flush pads the
// pending bits to a byte. The table read is registered when a transaction is accepted,
// and the pack stage then writes its bytes into the output buffer when it retires, which
// can wait for the buffer to drain. One transaction is accepted per cycle while the input
// is not stalled; the single-byte output port is the limit, so an encode that completes
// two bytes holds off the next byte-emitting transaction while they drain. A transaction
// that emits nothing never waits for the output side.
module huffman_code_table_bit_packer #(
  parameter int MAX_CODE_LEN = 16,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hcp_pkg::KIND_W-1:0]        in_kind,
  input  logic [hcp_pkg::SYMBOL_W-1:0]      in_symbol,
  input  logic [hcp_pkg::CODE_FIELD_W-1:0]  in_code_bits,
  input  logic [hcp_pkg::CODE_LEN_W-1:0]    in_code_length,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hcp_pkg::BYTE_W-1:0]        out_packed_byte,
  output logic                              out_last_of_run
);
  import hcp_pkg::*;

  localparam int CODE_W = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int SYM_W  = $clog2(SYMBOL_COUNT);

  logic                    in_acc;
  logic                    out_acc;
  logic                    sym_ok;
  logic [LEN_W-1:0]        len_sat;
  logic [CODE_FIELD_W-1:0] code_msk;
  logic [CODE_W-1:0]       wr_code;
  logic                    wr_en;
  logic [CODE_W-1:0]       rd_code;
  logic [LEN_W-1:0]        rd_len;

  logic                    s1_vld_r, s1_vld_nxt;
  kind_t                   s1_kind_r;
  logic                    s1_hit_r;

  logic [PEND_W-1:0]       pend_bits_r, pend_bits_nxt;
  logic [PCNT_W-1:0]       pend_cnt_r, pend_cnt_nxt;

  logic [NB_W-1:0]         ob_cnt_r, ob_cnt_nxt;
  logic [BYTE_W-1:0]       ob_b0_r, ob_b0_nxt;
  logic [BYTE_W-1:0]       ob_b1_r, ob_b1_nxt;

  logic [CODE_W-1:0]       enc_code;
  logic [LEN_W-1:0]        enc_len;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        acc_shf;
  logic [SUM_W-1:0]        cnt;
  logic [NB_W-1:0]         nbytes;
  logic [BYTE_W-1:0]       byte0;
  logic [BYTE_W-1:0]       byte1;
  logic [PEND_W-1:0]       pack_bits;
  logic [PCNT_W-1:0]       pack_cnt;
  logic                    retire;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // load path: range check, length saturation, stray bit removal
  assign sym_ok   = 9'(in_symbol) < 9'(SYMBOL_COUNT);
  assign len_sat  = (in_code_length > CODE_LEN_W'(CODE_W)) ? LEN_W'(CODE_W)
                                                           : in_code_length[LEN_W-1:0];
  assign code_msk = ~({CODE_FIELD_W{1'b1}} << len_sat);
  assign wr_code  = CODE_W'(in_code_bits & code_msk);
  assign wr_en    = in_acc && sym_ok && (in_kind == KIND_LOAD);

  hcp_code_mem #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .CODE_W       (CODE_W),
    .LEN_W        (LEN_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .rd_en   (in_acc),
    .addr    (in_symbol[SYM_W-1:0]),
    .wr_code (wr_code),
    .wr_len  (len_sat),
    .rd_code (rd_code),
    .rd_len  (rd_len)
  );

  // pack stage: merge looked-up code into the pending bits
  assign enc_code = s1_hit_r ? rd_code : '0;
  assign enc_len  = s1_hit_r ? rd_len  : '0;
  assign acc      = ACC_W'(pend_bits_r) | (ACC_W'(enc_code) << pend_cnt_r);
  assign cnt      = SUM_W'(pend_cnt_r) + SUM_W'(enc_len);
  assign acc_shf  = acc >> {cnt[SUM_W-1:PCNT_W], 3'b000};

  always_comb begin
    nbytes    = '0;
    byte0     = acc[BYTE_W-1:0];
    byte1     = acc[2*BYTE_W-1:BYTE_W];
    pack_bits = pend_bits_r;
    pack_cnt  = pend_cnt_r;
    case (s1_kind_r)
      KIND_ENCODE: begin
        nbytes    = cnt[SUM_W-1:PCNT_W];
        pack_bits = acc_shf[PEND_W-1:0];
        pack_cnt  = cnt[PCNT_W-1:0];
      end
      KIND_FLUSH: begin
        if (pend_cnt_r != '0) begin
          nbytes    = NB_W'(1);
          byte0     = BYTE_W'(pend_bits_r);
          pack_bits = '0;
          pack_cnt  = '0;
        end
      end
      default: begin
        nbytes = '0;
      end
    endcase
  end

  // the pack stage retires once the output buffer can take its bytes
  assign retire   = s1_vld_r && ((nbytes == '0) || (ob_cnt_r == '0) ||
                                 ((ob_cnt_r == NB_W'(1)) && out_acc));
  assign in_stall = s1_vld_r && !retire;

  // next state of pack stage, pending bits and output buffer
  always_comb begin
    s1_vld_nxt    = in_acc ? 1'b1 : (retire ? 1'b0 : s1_vld_r);
    pend_bits_nxt = retire ? pack_bits : pend_bits_r;
    pend_cnt_nxt  = retire ? pack_cnt  : pend_cnt_r;
    ob_cnt_nxt    = ob_cnt_r;
    ob_b0_nxt     = ob_b0_r;
    ob_b1_nxt     = ob_b1_r;
    if (retire && (nbytes != '0)) begin
      ob_cnt_nxt = nbytes;
      ob_b0_nxt  = byte0;
      ob_b1_nxt  = byte1;
    end else if (out_acc) begin
      ob_cnt_nxt = ob_cnt_r - NB_W'(1);
      ob_b0_nxt  = ob_b1_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      ob_cnt_r    <= '0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      ob_cnt_r    <= ob_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= kind_t'(in_kind);
      s1_hit_r  <= sym_ok;
    end
    ob_b0_r <= ob_b0_nxt;
    ob_b1_r <= ob_b1_nxt;
  end

  // result port: a buffer holds the remaining bytes of one transaction
  assign out_valid       = ob_cnt_r != '0;
  assign out_packed_byte = ob_b0_r;
  assign out_last_of_run = ob_cnt_r == NB_W'(1);

endmodule

FILE: hw/rtl/hcp_code_mem.sv
module hcp_code_mem #(
  parameter int SYMBOL_COUNT = 256,
  parameter int CODE_W       = 16,
  parameter int LEN_W        = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic                            rd_en,
  input  logic [$clog2(SYMBOL_COUNT)-1:0] addr,
  input  logic [CODE_W-1:0]               wr_code,
  input  logic [LEN_W-1:0]                wr_len,
  output logic [CODE_W-1:0]               rd_code,
  output logic [LEN_W-1:0]                rd_len
);
  import hcp_pkg::*;

  localparam int ENTRY_W = CODE_W + LEN_W;

  logic [ENTRY_W-1:0]      tbl_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_r;
  logic                    rd_vld_r;
  logic [ENTRY_W-1:0]      rd_data_r;

  // table storage with registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[addr] <= {wr_len, wr_code};
    end
    if (rd_en) begin
      rd_data_r <= tbl_mem[addr];
    end
  end

  // per-entry valid bits, an entry never loaded reads as zero length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  // gate the read entry with its valid bit
  assign rd_code = rd_vld_r ? rd_data_r[CODE_W-1:0]       : '0;
  assign rd_len  = rd_vld_r ? rd_data_r[ENTRY_W-1:CODE_W] : '0;

endmodule

FILE: hw/rtl/hcp_checker.sv
module hcp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [hcp_pkg::BYTE_W-1:0]   out_packed_byte,
  input logic                         out_last_of_run
);
  import hcp_pkg::*;

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_packed_byte) &&
                               $stable(out_last_of_run))
    else $error("result payload changed while stalled");

  // input backpressure only comes from a busy result port
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result port");

  // a byte that is not the last of its run is followed by another
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("run ended without last flag");

  // clean state right after reset
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind huffman_code_table_bit_packer hcp_checker u_hcp_checker (.*);
